// File: hdl/scfcb_pkg.sv
// Package with frame constants, shared types and the CRC-16 byte update.
`timescale 1ns / 1ps

package scfcb_pkg;

    localparam int FRAME_BYTES = 24;
    localparam int CRC_FIRST   = 4;
    localparam int CRC_LENGTH  = 18;

    localparam int POS_W = $clog2(FRAME_BYTES);

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

    localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(FRAME_BYTES - 1);

    localparam int TDATA_OUT_W = 32;

    typedef enum logic
    {
        MODE_BUILD = 1'b0,
        MODE_CHECK = 1'b1
    } frame_mode_t;

    typedef struct packed
    {
        frame_mode_t req_type;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed
    {
        logic [15:0] crc_running;
        logic        crc_ok;
        logic        last_byte;
        logic [4:0]  byte_index;
        logic [7:0]  out_byte;
    } result_t;

    // One reflected CRC-16/MODBUS byte step.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Byte lies inside the covered span and ahead of the CRC bytes.
    function automatic logic crc_covered(input logic [POS_W-1:0] p);
        return (32'(p) >= 32'(CRC_FIRST))
            && (32'(p) < 32'(CRC_FIRST + CRC_LENGTH))
            && (32'(p) < 32'(FRAME_BYTES - 2));
    endfunction

endpackage

// File: hdl/scfcb_in_stage.sv
// Input register stage holding one accepted transaction.
`timescale 1ns / 1ps

module scfcb_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic           s_axis_tuser,   // [0] req_type
    input  logic [7:0]     s_axis_tdata,   // [7:0] data_byte
    input  logic           advance,
    output logic           item_valid,
    output scfcb_pkg::item_t item
);

    logic             valid_reg;
    logic             valid_next;
    scfcb_pkg::item_t item_reg;
    logic             load;

    assign s_axis_tready = !valid_reg || advance;
    assign load          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        valid_next = load || (valid_reg && !advance);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.req_type  <= scfcb_pkg::frame_mode_t'(s_axis_tuser);
            item_reg.data_byte <= s_axis_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: hdl/scfcb_frame_core.sv
// Frame position, mode and CRC state with the per-byte result logic.
`timescale 1ns / 1ps

module scfcb_frame_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  scfcb_pkg::item_t   item,
    output scfcb_pkg::result_t result
);

    logic [scfcb_pkg::POS_W-1:0] position_reg;
    logic [scfcb_pkg::POS_W-1:0] position_next;
    logic [15:0]                 crc_reg;
    logic [15:0]                 crc_next;
    logic [7:0]                  rx_low_reg;
    logic [7:0]                  rx_low_next;
    scfcb_pkg::frame_mode_t      mode_reg;
    scfcb_pkg::frame_mode_t      mode_next;

    logic        frame_start;
    logic [15:0] crc_base;

    always_comb
    begin
        frame_start = (position_reg == '0);
        mode_next   = frame_start ? item.req_type : mode_reg;
        crc_base    = frame_start ? scfcb_pkg::CRC_INIT : crc_reg;
        crc_next    = scfcb_pkg::crc_covered(position_reg)
                    ? scfcb_pkg::crc16_update(crc_base, item.data_byte) : crc_base;

        rx_low_next = rx_low_reg;
        result.out_byte    = item.data_byte;
        result.byte_index  = 5'(position_reg);
        result.last_byte   = 1'b0;
        result.crc_ok      = 1'b0;
        result.crc_running = crc_next;

        if (position_reg == scfcb_pkg::POS_CRC_LO)
        begin
            if (mode_next == scfcb_pkg::MODE_BUILD)
            begin
                result.out_byte = crc_next[7:0];
            end
            else
            begin
                rx_low_next = item.data_byte;
            end
        end
        else if (position_reg == scfcb_pkg::POS_CRC_HI)
        begin
            result.last_byte = 1'b1;
            if (mode_next == scfcb_pkg::MODE_BUILD)
            begin
                result.out_byte = crc_next[15:8];
            end
            else
            begin
                result.crc_ok = ({item.data_byte, rx_low_reg} == crc_next);
            end
        end

        // wrap after the last byte
        if (position_reg >= scfcb_pkg::POS_CRC_HI)
        begin
            position_next = '0;
        end
        else
        begin
            position_next = position_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            crc_reg      <= scfcb_pkg::CRC_INIT;
            rx_low_reg   <= 8'h00;
            mode_reg     <= scfcb_pkg::MODE_BUILD;
        end
        else if (advance)
        begin
            position_reg <= position_next;
            crc_reg      <= crc_next;
            rx_low_reg   <= rx_low_next;
            mode_reg     <= mode_next;
        end
    end

endmodule

// File: hdl/scfcb_out_stage.sv
// Output register stage driving the result stream.
`timescale 1ns / 1ps

module scfcb_out_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  scfcb_pkg::result_t result,
    output logic               advance,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [7:0] out_byte, [12:8] byte_index, [13] crc_ok, [29:14] crc_running, [31:30] zero
    output logic [scfcb_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    output logic               m_axis_tlast
);

    logic               valid_reg;
    logic               valid_next;
    scfcb_pkg::result_t result_reg;

    // take a new result when the register is empty or being drained
    assign advance = item_valid && (!valid_reg || m_axis_tready);

    always_comb
    begin
        valid_next = advance || (valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tlast  = result_reg.last_byte;
    assign m_axis_tdata  = {2'b00, result_reg.crc_running, result_reg.crc_ok,
                            result_reg.byte_index, result_reg.out_byte};

endmodule

// File: hdl/sensor_frame_crc_builder_checker.sv
// Top level of the sensor frame CRC builder and checker.
`timescale 1ns / 1ps

// Streams fixed 24-byte sensor frames, one byte per transaction.
// Slave side: s_axis_tdata carries the byte, s_axis_tuser the request type
// (sampled on the first byte of each frame: 0 build, 1 check).
// Build frames get the CRC-16/MODBUS of bytes 4..21 in bytes 22 and 23,
// low byte first. Check frames pass through and flag crc_ok on the last byte.
// Master side: tdata holds the output byte, its index in the frame, crc_ok and
// the running CRC; tlast marks the last byte of the frame.
// Datapath: a byte accepted into the input register passes the combinational
// frame core and is presented from the output register.
// Throughput: one byte per cycle while the master does not stall, with the
// CRC byte update combinational between the input and output registers.
// Reset: both stages empty, position back to the first byte, CRC at 0xFFFF.
// A stalled master holds the output register; the input register still takes
// one more byte if it is empty, then s_axis_tready drops until the output drains.

module sensor_frame_crc_builder_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_byte, [12:8] byte_index, [13] crc_ok, [29:14] crc_running, [31:30] zero
    output logic [scfcb_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    logic               advance;
    logic               item_valid;
    scfcb_pkg::item_t   item;
    scfcb_pkg::result_t result;

    scfcb_in_stage u_in_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    scfcb_frame_core u_frame_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    scfcb_out_stage u_out_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .result        (result),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
